@@ hw/rtl/ajf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the audio jitter FIFO.
// No dependencies; every other file of the block imports this package.
package ajf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FILL_W     = 13;
    localparam int CHCNT_W    = 4;
    localparam int CH_W       = 3;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_FRAMES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WATER    = 2'd2;

    localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;
    localparam logic [FILL_W-1:0]  RING_FRAMES_RST   = 13'd3840;
    localparam logic [FILL_W-1:0]  HIGH_WATER_RST    = 13'd1728;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_DROP  = 2'd3
    } ajf_kind_t;

    typedef struct packed {
        ajf_kind_t                  kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       packet_start;
        logic [FILL_W-1:0]          packet_frames;
        logic                       callback_end;
    } ajf_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic [CH_W-1:0]            channel_index;
        logic                       frame_last;
        logic                       silence_filled;
        logic [CNT_W-1:0]           underrun_total;
        logic [CNT_W-1:0]           drop_total;
        logic [CNT_W-1:0]           reopen_total;
        logic [FILL_W-1:0]          fill_level;
    } ajf_rsp_t;

    // Everything a frame read needs besides the ring row
    typedef struct packed {
        logic [CHCNT_W-1:0] chans;
        logic               silent;
        logic [CNT_W-1:0]   underrun;
        logic [CNT_W-1:0]   drop;
        logic [CNT_W-1:0]   reopen;
        logic [FILL_W-1:0]  fill;
    } ajf_burst_meta_t;

    // Read engine status seen by the control logic
    typedef struct packed {
        logic load_ok;
        logic row_busy;
    } ajf_burst_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ hw/rtl/ajf_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the audio jitter FIFO: request, response, configuration.
// Depends on ajf_pkg for the payload types.
interface ajf_req_if;
    import ajf_pkg::*;
    logic     valid;
    logic     ready;
    ajf_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ajf_rsp_if;
    import ajf_pkg::*;
    logic     valid;
    logic     ready;
    ajf_rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ajf_cfg_if;
    import ajf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ajf_ring_ram.sv @@
`timescale 1ns / 1ps
// Sample store: one write port, one registered read port.
// Depends on ajf_pkg for the sample width.
module ajf_ring_ram
    import ajf_pkg::*;
#(
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/ajf_ctrl.sv @@
`timescale 1ns / 1ps
// Ring control: configuration registers, positions, fill, packet tracking, counters.
// Depends on ajf_pkg; drives the store write port and loads the read engine.
module ajf_ctrl
    import ajf_pkg::*;
#(
    parameter int RING_DEPTH   = 4096,
    parameter int MAX_CHANNELS = 8,
    localparam int PW = ($clog2(RING_DEPTH) < FILL_W) ? $clog2(RING_DEPTH) : FILL_W,
    localparam int ADDR_W = $clog2(RING_DEPTH * MAX_CHANNELS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ajf_req_t              in_data,
    output logic                  in_ready,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cfg_ready,
    input  ajf_burst_stat_t       bstat,
    output logic [PW-1:0]         probe_row,
    output logic                  load,
    output logic [PW-1:0]         load_row,
    output ajf_burst_meta_t       load_meta,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [SAMPLE_W-1:0]   wr_data
);

    localparam int RING_LIM = (RING_DEPTH > (1 << FILL_W) - 1) ? (1 << FILL_W) - 1 : RING_DEPTH;

    logic [CHCNT_W-1:0] cc_reg, cc_next;
    logic [FILL_W-1:0]  rf_reg, rf_next;
    logic [FILL_W-1:0]  hw_reg, hw_next;
    logic [PW-1:0]      rp_reg, rp_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  pend_reg, pend_next;
    logic [FILL_W-1:0]  psize_reg, psize_next;
    logic [CH_W-1:0]    wch_reg, wch_next;
    logic               acc_reg, acc_next;
    logic               prod_reg, prod_next;
    logic               short_reg, short_next;
    logic [CNT_W-1:0]   und_reg, und_next;
    logic [CNT_W-1:0]   drop_reg, drop_next;
    logic [CNT_W-1:0]   reopen_reg, reopen_next;

    logic [CHCNT_W-1:0] chans_eff;
    logic [FILL_W-1:0]  ring_eff;
    logic [FILL_W:0]    end_sum;
    logic [PW-1:0]      end_pos;
    logic [FILL_W:0]    fill_sum;
    logic               accept;
    logic               clear;
    logic               silent;

    // clamp out-of-range geometry
    always_comb
    begin
        priority if (cc_reg == '0)
            chans_eff = CHCNT_W'(1);
        else if (int'(cc_reg) > MAX_CHANNELS)
            chans_eff = CHCNT_W'(MAX_CHANNELS);
        else
            chans_eff = cc_reg;

        priority if (rf_reg == '0)
            ring_eff = FILL_W'(1);
        else if (int'(rf_reg) > RING_DEPTH)
            ring_eff = FILL_W'(RING_LIM);
        else
            ring_eff = rf_reg;
    end

    // first free row behind the committed frames
    assign end_sum = {1'b0, FILL_W'(rp_reg)} + {1'b0, fill_reg};
    assign end_pos = (end_sum >= {1'b0, ring_eff}) ? PW'(end_sum - {1'b0, ring_eff})
                                                   : PW'(end_sum);
    assign probe_row = in_data.packet_start ? end_pos : wp_reg;

    // hold requests in a cycle that takes a register write, reads while the engine cannot load, writes to a busy row
    always_comb
    begin
        unique case (in_data.kind)
            KIND_READ:  in_ready = bstat.load_ok && !cfg_valid;
            KIND_WRITE: in_ready = !bstat.row_busy && !cfg_valid;
            default:    in_ready = !cfg_valid;
        endcase
    end

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign wr_data   = in_data.sample;
    assign load_row  = rp_reg;

    always_comb
    begin
        cc_next     = cc_reg;
        rf_next     = rf_reg;
        hw_next     = hw_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        psize_next  = psize_reg;
        wch_next    = wch_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        short_next  = short_reg;
        und_next    = und_reg;
        drop_next   = drop_reg;
        reopen_next = reopen_reg;
        clear       = 1'b0;
        silent      = (fill_reg == '0);
        fill_sum    = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        load        = 1'b0;

        priority if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT:
                begin
                    cc_next = cfg_data[CHCNT_W-1:0];
                    clear   = 1'b1;
                end
                CFG_RING_FRAMES:
                begin
                    rf_next = cfg_data;
                    clear   = 1'b1;
                end
                CFG_HIGH_WATER:
                begin
                    hw_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            unique case (in_data.kind)
                KIND_WRITE:
                begin
                    // a packet start abandons any unfinished packet
                    if (in_data.packet_start)
                    begin
                        wp_next   = end_pos;
                        wch_next  = '0;
                        pend_next = '0;
                        acc_next  = 1'b0;
                        if (in_data.packet_frames != '0)
                        begin
                            if (fill_reg >= hw_reg ||
                                ({1'b0, fill_reg} + {1'b0, in_data.packet_frames}) >
                                {1'b0, ring_eff})
                            begin
                                drop_next = sat_inc(drop_reg);
                            end
                            else
                            begin
                                acc_next   = 1'b1;
                                pend_next  = in_data.packet_frames;
                                psize_next = in_data.packet_frames;
                            end
                        end
                    end
                    if (acc_next && pend_next != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(wp_next) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(wch_next);
                        if (({1'b0, wch_next} + CHCNT_W'(1)) >= chans_eff)
                        begin
                            wch_next  = '0;
                            wp_next   = (FILL_W'(wp_next) + FILL_W'(1) >= ring_eff)
                                        ? '0 : wp_next + PW'(1);
                            pend_next = pend_next - FILL_W'(1);
                            if (pend_next == '0)
                            begin
                                // packet complete: commit its frames
                                fill_sum  = {1'b0, fill_next} + {1'b0, psize_next};
                                fill_next = (fill_sum > {1'b0, ring_eff}) ? ring_eff
                                                                          : FILL_W'(fill_sum);
                                prod_next = 1'b1;
                                acc_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            wch_next = wch_next + CH_W'(1);
                        end
                    end
                end
                KIND_READ:
                begin
                    load = 1'b1;
                    if (!silent)
                    begin
                        rp_next   = (FILL_W'(rp_reg) + FILL_W'(1) >= ring_eff)
                                    ? '0 : rp_reg + PW'(1);
                        fill_next = fill_reg - FILL_W'(1);
                    end
                    else if (prod_reg)
                    begin
                        short_next = 1'b1;
                    end
                    if (in_data.callback_end)
                    begin
                        if (short_next)
                        begin
                            und_next = sat_inc(und_reg);
                        end
                        short_next = 1'b0;
                    end
                end
                KIND_FLUSH:
                begin
                    clear       = 1'b1;
                    reopen_next = sat_inc(reopen_reg);
                end
                KIND_DROP:
                begin
                    drop_next = sat_inc(drop_reg);
                end
            endcase
        end

        if (clear)
        begin
            rp_next    = '0;
            wp_next    = '0;
            fill_next  = '0;
            pend_next  = '0;
            psize_next = '0;
            wch_next   = '0;
            acc_next   = 1'b0;
            prod_next  = 1'b0;
        end

        load_meta.chans    = chans_eff;
        load_meta.silent   = silent;
        load_meta.underrun = und_next;
        load_meta.drop     = drop_reg;
        load_meta.reopen   = reopen_reg;
        load_meta.fill     = fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg     <= CHANNEL_COUNT_RST;
            rf_reg     <= RING_FRAMES_RST;
            hw_reg     <= HIGH_WATER_RST;
            rp_reg     <= '0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            pend_reg   <= '0;
            psize_reg  <= '0;
            wch_reg    <= '0;
            acc_reg    <= 1'b0;
            prod_reg   <= 1'b0;
            short_reg  <= 1'b0;
            und_reg    <= '0;
            drop_reg   <= '0;
            reopen_reg <= '0;
        end
        else
        begin
            cc_reg     <= cc_next;
            rf_reg     <= rf_next;
            hw_reg     <= hw_next;
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            psize_reg  <= psize_next;
            wch_reg    <= wch_next;
            acc_reg    <= acc_next;
            prod_reg   <= prod_next;
            short_reg  <= short_next;
            und_reg    <= und_next;
            drop_reg   <= drop_next;
            reopen_reg <= reopen_next;
        end
    end

endmodule

@@ hw/rtl/ajf_burst.sv @@
`timescale 1ns / 1ps
// Frame read engine: issues one store read per channel and registers the results.
// Depends on ajf_pkg; reads through the store read port.
module ajf_burst
    import ajf_pkg::*;
#(
    parameter int RING_DEPTH   = 4096,
    parameter int MAX_CHANNELS = 8,
    localparam int PW = ($clog2(RING_DEPTH) < FILL_W) ? $clog2(RING_DEPTH) : FILL_W,
    localparam int ADDR_W = $clog2(RING_DEPTH * MAX_CHANNELS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [PW-1:0]       load_row,
    input  ajf_burst_meta_t     load_meta,
    input  logic [PW-1:0]       probe_row,
    output ajf_burst_stat_t     stat,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    input  logic [SAMPLE_W-1:0] rd_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ajf_rsp_t            out_data
);

    logic            act_reg;
    logic [CH_W-1:0] ch_reg;
    logic [PW-1:0]   row_reg;
    ajf_burst_meta_t meta_reg;
    logic            s1_valid_reg;
    ajf_rsp_t        s1_reg;
    logic            o_valid_reg;
    ajf_rsp_t        o_reg;
    ajf_rsp_t        o_next;

    logic            s1_move;
    logic            issue;
    logic            last;
    ajf_rsp_t        slot;

    assign s1_move = s1_valid_reg && (!o_valid_reg || out_ready);
    assign issue   = act_reg && (!s1_valid_reg || s1_move);
    assign last    = ({1'b0, ch_reg} + CHCNT_W'(1)) >= meta_reg.chans;

    assign stat.load_ok  = !act_reg || (issue && last);
    // a write must not land on a row whose samples are still to be read
    assign stat.row_busy = act_reg && !meta_reg.silent && (row_reg == probe_row);

    assign rd_en   = issue;
    assign rd_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch_reg);

    always_comb
    begin
        slot.out_sample     = '0;
        slot.channel_index  = ch_reg;
        slot.frame_last     = last;
        slot.silence_filled = meta_reg.silent;
        slot.underrun_total = meta_reg.underrun;
        slot.drop_total     = meta_reg.drop;
        slot.reopen_total   = meta_reg.reopen;
        slot.fill_level     = meta_reg.fill;
    end

    // merge the store sample into the staged response
    always_comb
    begin
        o_next            = s1_reg;
        o_next.out_sample = s1_reg.silence_filled ? '0 : rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= 1'b0;
            ch_reg       <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                act_reg <= 1'b1;
                ch_reg  <= '0;
            end
            else if (issue)
            begin
                if (last)
                    act_reg <= 1'b0;
                else
                    ch_reg <= ch_reg + CH_W'(1);
            end

            if (issue)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                o_valid_reg <= 1'b1;
            else if (out_ready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= load_row;
            meta_reg <= load_meta;
        end
        if (issue)
        begin
            s1_reg <= slot;
        end
        if (s1_move)
        begin
            o_reg <= o_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_reg;

endmodule

@@ hw/rtl/audio_jitter_fifo_with_drop_core.sv @@
`timescale 1ns / 1ps
// Top level of the audio jitter FIFO: ring control, frame read engine, sample store.
// Depends on ajf_pkg, ajf_if, ajf_ctrl, ajf_burst and ajf_ring_ram.
//
//  channel | direction | transaction moves
//  --------+-----------+-----------------------------------------------------
//  req     | in        | one sample write, frame read, flush or external drop
//  rsp     | out       | one channel sample of a frame with counters and fill
//  cfg     | in        | one register write (index, data)
//
// Sample writes, flushes and external drops give no response. A frame read
// gives channel_count response transactions, one per cycle while the receiver
// does not stall; that rate is set by the single read port of the sample
// store. A read waits while the previous frame still issues its store reads,
// and a sample write waits while it would land on the row of a frame still
// being read. A request also waits in a cycle that carries a register write.
// Reset clears all control state at once; the store needs no clearing pass.
module audio_jitter_fifo_with_drop_core
    import ajf_pkg::*;
#(
    parameter int RING_DEPTH   = 4096,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    ajf_req_if.sink        req,
    ajf_rsp_if.source      rsp,
    ajf_cfg_if.sink        cfg
);

    localparam int PW = ($clog2(RING_DEPTH) < FILL_W) ? $clog2(RING_DEPTH) : FILL_W;
    localparam int ADDR_W = $clog2(RING_DEPTH * MAX_CHANNELS);

    // control to read engine
    ajf_burst_stat_t     bstat;
    logic [PW-1:0]       probe_row;
    logic                load;
    logic [PW-1:0]       load_row;
    ajf_burst_meta_t     load_meta;

    // store ports
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data;

    logic                req_ready;
    logic                cfg_ready;
    logic                rsp_valid;
    ajf_rsp_t            rsp_data;

    // Hold all ring state in flops and update it at the accepted transaction;
    // a frame read snapshots the counters and fill as they stand after it.
    ajf_ctrl #(
        .RING_DEPTH   (RING_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_data   (req.payload),
        .in_ready  (req_ready),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cfg_ready (cfg_ready),
        .bstat     (bstat),
        .probe_row (probe_row),
        .load      (load),
        .load_row  (load_row),
        .load_meta (load_meta),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Advance one channel per cycle through the store read port; the output
    // register holds each response transaction while the receiver stalls.
    ajf_burst #(
        .RING_DEPTH   (RING_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_row  (load_row),
        .load_meta (load_meta),
        .probe_row (probe_row),
        .stat      (bstat),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_data)
    );

    // One row of MAX_CHANNELS samples per ring frame
    ajf_ring_ram #(
        .DEPTH (RING_DEPTH * MAX_CHANNELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready   = req_ready;
    assign cfg.ready   = cfg_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_data;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of audio_jitter_fifo_with_drop_core.
// Depends on ajf_pkg, the ajf_if channel interfaces and the block's RTL.
module tb;
    import ajf_pkg::*;

    // Geometry of the instance under test; the ring model below uses the same sizes
    localparam int DEPTH = 4096;
    localparam int MAXCH = 8;

    // Index 3 of the configuration port maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles the receiver holds off in the pressure phase
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    ajf_req_if req_ch ();
    ajf_rsp_if rsp_ch ();
    ajf_cfg_if cfg_ch ();

    audio_jitter_fifo_with_drop_core #(
        .RING_DEPTH   (DEPTH),
        .MAX_CHANNELS (MAXCH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // ------------------------------------------------------------------
    // Ring model: registers, positions, counters and the sample store
    // ------------------------------------------------------------------
    logic [CHCNT_W-1:0] reg_chans;
    logic [FILL_W-1:0]  reg_ring;
    logic [FILL_W-1:0]  reg_hw;

    logic [SAMPLE_W-1:0] pcm_store [0:DEPTH*MAXCH-1];
    int unsigned rd_pos;
    int unsigned wr_pos;
    int unsigned fill;
    int unsigned pend;
    int unsigned pkt_size;
    int unsigned wr_ch;
    bit          pkt_open;
    bit          producing;
    bit          cb_short;
    logic [CNT_W-1:0] underrun_cnt;
    logic [CNT_W-1:0] drop_cnt;
    logic [CNT_W-1:0] reopen_cnt;

    // Frame samples of the last modeled read, and all samples still to come
    ajf_rsp_t frame_pred [$];
    ajf_rsp_t expected_samples [$];

    // Stimulus control shared with the receiver process
    bit quiet;      // no idling on either side
    bit steady;     // sender offers back to back
    bit hold_req;   // receiver holds off for HOLD_CYCLES

    int fail_count;
    int item_count;
    int read_count;
    int sample_count;
    int reg_writes;

    typedef struct {
        ajf_req_t         req;
        bit               typed;
        logic [CNT_W-1:0] t_under;
        logic [CNT_W-1:0] t_drop;
        logic [CNT_W-1:0] t_reopen;
        logic [FILL_W-1:0] t_fill;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic int unsigned live_chans();
        if (reg_chans == 0) return 1;
        if (reg_chans > MAXCH) return MAXCH;
        return 32'(reg_chans);
    endfunction

    function automatic int unsigned live_ring();
        if (reg_ring == 0) return 1;
        if (reg_ring > DEPTH) return DEPTH;
        return 32'(reg_ring);
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1;
    endfunction

    // Abandon the packet in progress and empty the ring
    function automatic void clear_ring_model();
        rd_pos    = 0;
        wr_pos    = 0;
        fill      = 0;
        pend      = 0;
        pkt_size  = 0;
        wr_ch     = 0;
        pkt_open  = 0;
        producing = 0;
    endfunction

    function automatic void model_sample(input logic [SAMPLE_W-1:0] s, input bit start,
                                         input int unsigned frames);
        int unsigned ring;
        int unsigned chans;
        int unsigned tail;
        ring  = live_ring();
        chans = live_chans();
        if (start)
        begin
            // A new packet always restarts at the committed tail
            tail = rd_pos + fill;
            if (tail >= ring) tail -= ring;
            wr_pos   = tail;
            wr_ch    = 0;
            pend     = 0;
            pkt_open = 0;
            if (frames != 0)
            begin
                if (fill >= reg_hw || fill + frames > ring)
                    drop_cnt = bump(drop_cnt);
                else
                begin
                    pkt_open = 1;
                    pend     = frames;
                    pkt_size = frames;
                end
            end
        end
        if (!pkt_open || pend == 0) return;
        pcm_store[(wr_pos % DEPTH) * MAXCH + (wr_ch % MAXCH)] = s;
        wr_ch++;
        if (wr_ch >= chans)
        begin
            wr_ch = 0;
            wr_pos++;
            if (wr_pos >= ring) wr_pos = 0;
            pend--;
            if (pend == 0)
            begin
                // Last sample of the packet: commit every frame at once
                fill += pkt_size;
                if (fill > ring) fill = ring;
                producing = 1;
                pkt_open  = 0;
            end
        end
    endfunction

    // Advance the model by one request; a read leaves its frame in frame_pred
    function automatic void ring_model_step(input ajf_req_t r);
        int unsigned chans;
        int unsigned ring;
        bit          silent;
        ajf_rsp_t    e;
        frame_pred.delete();
        case (r.kind)
            KIND_WRITE: model_sample(r.sample, r.packet_start, r.packet_frames);
            KIND_FLUSH:
            begin
                clear_ring_model();
                reopen_cnt = bump(reopen_cnt);
            end
            KIND_DROP: drop_cnt = bump(drop_cnt);
            default:
            begin
                chans  = live_chans();
                ring   = live_ring();
                silent = (fill == 0);
                for (int c = 0; c < chans; c++)
                begin
                    e = '0;
                    e.out_sample     = silent ? '0 : pcm_store[(rd_pos % DEPTH) * MAXCH + c];
                    e.channel_index  = c[CH_W-1:0];
                    e.frame_last     = (c + 1 == chans);
                    e.silence_filled = silent;
                    frame_pred.push_back(e);
                end
                if (silent)
                begin
                    if (producing) cb_short = 1;
                end
                else
                begin
                    rd_pos++;
                    if (rd_pos >= ring) rd_pos = 0;
                    fill--;
                end
                if (r.callback_end)
                begin
                    if (cb_short) underrun_cnt = bump(underrun_cnt);
                    cb_short = 0;
                end
                foreach (frame_pred[i])
                begin
                    frame_pred[i].underrun_total = underrun_cnt;
                    frame_pred[i].drop_total     = drop_cnt;
                    frame_pred[i].reopen_total   = reopen_cnt;
                    frame_pred[i].fill_level     = fill[FILL_W-1:0];
                end
            end
        endcase
    endfunction

    // Fully random request of the given kind; callers override what matters
    function automatic ajf_req_t rand_req(input ajf_kind_t k);
        ajf_req_t r;
        r.kind          = k;
        r.sample        = SAMPLE_W'($urandom_range(65535));
        r.packet_start  = 1'($urandom_range(1));
        r.packet_frames = FILL_W'($urandom_range(8191));
        r.callback_end  = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic void add_row(input ajf_kind_t k, input int s, input bit start,
                                    input int frames, input bit cb_end, input bit typed,
                                    input int under, input int drop, input int reopen,
                                    input int lvl);
        dir_row_t row;
        row.req.kind          = k;
        row.req.sample        = SAMPLE_W'(s);
        row.req.packet_start  = start;
        row.req.packet_frames = FILL_W'(frames);
        row.req.callback_end  = cb_end;
        row.typed             = typed;
        row.t_under           = CNT_W'(under);
        row.t_drop            = CNT_W'(drop);
        row.t_reopen          = CNT_W'(reopen);
        row.t_fill            = FILL_W'(lvl);
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: offer one request transaction, model it once it is taken.
    // A typed row replaces the modeled frame with hand-written values.
    // ------------------------------------------------------------------
    task automatic send_item(input ajf_req_t r, input bit typed, input dir_row_t row);
        int unsigned n;
        ajf_rsp_t    e;
        if (!quiet && !steady)
        begin
            while ($urandom_range(99) < 38)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        n = live_chans();
        ring_model_step(r);
        item_count++;
        if (r.kind == KIND_READ) read_count++;
        if (typed)
        begin
            for (int c = 0; c < n; c++)
            begin
                e = '0;
                e.channel_index  = c[CH_W-1:0];
                e.frame_last     = (c + 1 == n);
                e.silence_filled = 1'b1;
                e.underrun_total = row.t_under;
                e.drop_total     = row.t_drop;
                e.reopen_total   = row.t_reopen;
                e.fill_level     = row.t_fill;
                expected_samples.push_back(e);
            end
        end
        else
        begin
            foreach (frame_pred[i]) expected_samples.push_back(frame_pred[i]);
        end
    endtask

    // Register write transaction; the model follows once it is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_CHANNEL_COUNT:
            begin
                reg_chans = d[CHCNT_W-1:0];
                clear_ring_model();
            end
            CFG_RING_FRAMES:
            begin
                reg_ring = d;
                clear_ring_model();
            end
            CFG_HIGH_WATER: reg_hw = d;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold the sender until every frame sample has come back, then let
    // the last non-read transactions drain through the control logic
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Mostly well-formed packets and callbacks, plus flushes, drops and noise
    task automatic run_mix(input int n);
        int       sent;
        int       pick;
        int       frames;
        int       total;
        int       cut;
        int       k;
        ajf_req_t r;
        dir_row_t none;
        none = '{default: '0};
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 48)
            begin
                frames = ($urandom_range(9) == 0) ? $urandom_range(5, 12)
                                                  : $urandom_range(1, 4);
                total  = frames * live_chans();
                // Now and then cut the packet short so the next start abandons it
                cut    = ($urandom_range(9) == 0) ? $urandom_range(1, total) : total;
                // Keep the phase near its item budget
                if (cut > n - sent) cut = n - sent;
                for (int i = 0; i < cut; i++)
                begin
                    r = rand_req(KIND_WRITE);
                    r.packet_start = (i == 0);
                    if (i == 0) r.packet_frames = FILL_W'(frames);
                    send_item(r, 1'b0, none);
                    sent++;
                end
            end
            else if (pick < 84)
            begin
                k = $urandom_range(1, 4);
                for (int j = 0; j < k; j++)
                begin
                    r = rand_req(KIND_READ);
                    r.callback_end = (j == k - 1) ? ($urandom_range(3) != 0)
                                                  : ($urandom_range(5) == 0);
                    send_item(r, 1'b0, none);
                    sent++;
                end
            end
            else
            begin
                if (pick < 89)      r = rand_req(KIND_FLUSH);
                else if (pick < 93) r = rand_req(KIND_DROP);
                else                r = rand_req(KIND_WRITE);   // stray or oversized start
                send_item(r, 1'b0, none);
                sent++;
            end
        end
    endtask

    // Drain, program all three registers, then run a mixed phase
    task automatic phase(input logic [CFG_DATA_W-1:0] chans, input logic [CFG_DATA_W-1:0] ring,
                         input logic [CFG_DATA_W-1:0] hw, input int n);
        settle();
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_RING_FRAMES, ring);
        write_reg(CFG_HIGH_WATER, hw);
        run_mix(n);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, a long counted hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_cnt;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
                hold_req = 0;
            end
            else
            begin
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 38);
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Response checker: compare every transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ajf_rsp_t act;
        ajf_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            act = rsp_ch.payload;
            sample_count++;
            if (expected_samples.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected response sample=%0d ch=%0d", act.out_sample,
                             act.channel_index);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (act.out_sample     !== want.out_sample     ||
                    act.channel_index  !== want.channel_index  ||
                    act.frame_last     !== want.frame_last     ||
                    act.silence_filled !== want.silence_filled ||
                    act.underrun_total !== want.underrun_total ||
                    act.drop_total     !== want.drop_total     ||
                    act.reopen_total   !== want.reopen_total   ||
                    act.fill_level     !== want.fill_level)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("ERROR: mismatch at response %0d", sample_count);
                        $display({"  expected smp=%0d ch=%0d last=%0b sil=%0b",
                                  " und=%0d drp=%0d reo=%0d fill=%0d"},
                                 want.out_sample, want.channel_index, want.frame_last,
                                 want.silence_filled, want.underrun_total, want.drop_total,
                                 want.reopen_total, want.fill_level);
                        $display({"  actual   smp=%0d ch=%0d last=%0b sil=%0b",
                                  " und=%0d drp=%0d reo=%0d fill=%0d"},
                                 act.out_sample, act.channel_index, act.frame_last,
                                 act.silence_filled, act.underrun_total, act.drop_total,
                                 act.reopen_total, act.fill_level);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int       guard;
        ajf_req_t r;
        dir_row_t none;

        none           = '{default: '0};
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        quiet          = 0;
        steady         = 0;
        hold_req       = 0;
        fail_count     = 0;
        item_count     = 0;
        read_count     = 0;
        sample_count   = 0;
        reg_writes     = 0;

        // Model state after reset
        reg_chans    = CHANNEL_COUNT_RST;
        reg_ring     = RING_FRAMES_RST;
        reg_hw       = HIGH_WATER_RST;
        clear_ring_model();
        cb_short     = 0;
        underrun_cnt = '0;
        drop_cnt     = '0;
        reopen_cnt   = '0;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings: two channels, 3840 frames, mark 1728.
        // Typed rows are silent reads whose counters follow by simple counting.
        //      kind        sample  st frames cb typ und drp reo fill
        add_row(KIND_READ,       0, 0,    0, 1, 1,  0,  0,  0,  0);   // read of an empty ring
        add_row(KIND_DROP,       0, 0,    0, 0, 0,  0,  0,  0,  0);   // external drop
        add_row(KIND_READ,       0, 0,    0, 0, 1,  0,  1,  0,  0);
        add_row(KIND_FLUSH,      0, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_READ,       0, 0,    0, 0, 1,  0,  1,  1,  0);
        add_row(KIND_WRITE,    100, 1, 8191, 0, 0,  0,  0,  0,  0);   // largest size, no fit
        add_row(KIND_READ,       0, 0,    0, 0, 1,  0,  2,  1,  0);
        add_row(KIND_WRITE,      7, 1,    0, 0, 0,  0,  0,  0,  0);   // zero-length packet
        add_row(KIND_WRITE,      9, 0,    0, 0, 0,  0,  0,  0,  0);   // stray sample
        add_row(KIND_WRITE,  32767, 1,    1, 0, 0,  0,  0,  0,  0);   // sample extremes
        add_row(KIND_WRITE, -32768, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_READ,       0, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_READ,       0, 0,    0, 1, 0,  0,  0,  0,  0);   // underrun while producing
        add_row(KIND_WRITE,      1, 1,    2, 0, 0,  0,  0,  0,  0);
        add_row(KIND_WRITE,      2, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_WRITE,      3, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_WRITE,     -2, 1,    1, 0, 0,  0,  0,  0,  0);   // restart mid-packet
        add_row(KIND_WRITE,      5, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_READ,       0, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_WRITE,     11, 1, 4096, 0, 0,  0,  0,  0,  0);   // bigger than the ring
        add_row(KIND_WRITE,     -1, 1,    1, 0, 0,  0,  0,  0,  0);
        add_row(KIND_WRITE,      0, 0,    0, 0, 0,  0,  0,  0,  0);
        add_row(KIND_FLUSH,      0, 0,    0, 0, 0,  0,  0,  0,  0);   // flush a filled ring
        add_row(KIND_READ,       0, 0,    0, 1, 1,  1,  3,  2,  0);

        foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i]);

        // Register extremes: a small ring, largest geometry, out-of-range codes
        phase(13'd1,    13'd16,   13'd16,   40);
        phase(13'd8,    13'd4096, 13'd4096, 45);
        phase(13'h1FF0, 13'd0,    13'd1,    30);   // zero channel count and zero ring
        phase(13'd15,   13'd8191, 13'd0,    25);   // oversize codes, mark of zero drops all

        // Pressure: write three packets into the ring, then hold the receiver off while reads pile up
        settle();
        write_reg(CFG_CHANNEL_COUNT, 13'd4);
        write_reg(CFG_RING_FRAMES, 13'd64);
        write_reg(CFG_HIGH_WATER, 13'd40);
        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < 12; i++)
            begin
                r = rand_req(KIND_WRITE);
                r.packet_start = (i == 0);
                if (i == 0) r.packet_frames = 13'd3;
                send_item(r, 1'b0, none);
            end
        end
        steady   = 1;
        hold_req = 1;
        for (int i = 0; i < 12; i++)
        begin
            r = rand_req(KIND_READ);
            r.callback_end = (i == 11);
            send_item(r, 1'b0, none);
        end
        steady = 0;

        // Stretch with no idling on either side
        settle();
        quiet = 1;
        write_reg(CFG_CHANNEL_COUNT, 13'd2);
        write_reg(CFG_RING_FRAMES, 13'd24);
        write_reg(CFG_HIGH_WATER, 13'd8191);
        run_mix(35);
        quiet = 0;

        // Small ring with a low mark, and a write to the unused index
        settle();
        write_reg(CFG_SPARE, 13'h1ABC);
        phase(13'd3, 13'd20, 13'd6, 50);

        // Wait out the last responses, bounded
        req_ch.valid <= 1'b0;
        guard = 0;
        while (expected_samples.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            $display("ERROR: %0d response samples never arrived", expected_samples.size());
            fail_count++;
        end

        $display("Run: %0d requests (%0d frame reads), %0d response samples, %0d register writes",
                 item_count, read_count, sample_count, reg_writes);
        $display("Model counters at end: %0d drops, %0d underruns, %0d reopens; %0d failures",
                 drop_cnt, underrun_cnt, reopen_cnt, fail_count);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ajf_pkg.sv
hw/rtl/ajf_if.sv
hw/rtl/ajf_ring_ram.sv
hw/rtl/ajf_ctrl.sv
hw/rtl/ajf_burst.sv
hw/rtl/audio_jitter_fifo_with_drop_core.sv
dv/tb.sv
